FILE: hw/rtl/asf_pkg.sv
// Package for the arming supervisor: state and code types, constants and error evaluation.
`default_nettype none

package asf_pkg;

  // Default width of the stored error mask.
  localparam int unsigned ErrorWidthDef = 16;

  // Widths fixed by the interface.
  localparam int unsigned FuncW     = 4;
  localparam int unsigned MaskW     = 16;
  localparam int unsigned ThrottleW = 10;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 10;
  localparam int unsigned RcBitW    = 4;
  localparam int unsigned RejectW   = 2;

  // Supervisor states.
  typedef enum logic [2:0] {
    StInit        = 3'd0,
    StPreflight   = 3'd1,
    StError       = 3'd2,
    StCalibrating = 3'd3,
    StArmed       = 3'd4,
    StFailsafe    = 3'd5
  } state_e;

  // Input function codes.
  localparam logic [FuncW-1:0] FuncTick     = 4'd0;
  localparam logic [FuncW-1:0] FuncInitDone = 4'd1;
  localparam logic [FuncW-1:0] FuncRcFound  = 4'd2;
  localparam logic [FuncW-1:0] FuncRcLost   = 4'd3;
  localparam logic [FuncW-1:0] FuncArm      = 4'd4;
  localparam logic [FuncW-1:0] FuncDisarm   = 4'd5;
  localparam logic [FuncW-1:0] FuncCalDone  = 4'd6;
  localparam logic [FuncW-1:0] FuncCalFail  = 4'd7;
  localparam logic [FuncW-1:0] FuncSetErr   = 4'd8;
  localparam logic [FuncW-1:0] FuncClrErr   = 4'd9;

  // Arm reject codes.
  localparam logic [RejectW-1:0] RejNone     = 2'd0;
  localparam logic [RejectW-1:0] RejThrottle = 2'd1;
  localparam logic [RejectW-1:0] RejOverride = 2'd2;
  localparam logic [RejectW-1:0] RejReport   = 2'd3;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgArmThreshold   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgTakeMinThrottle = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgCalibrateOnArm = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgRcLostBit      = 2'd3;

  // Configuration reset values.
  localparam logic [ThrottleW-1:0] ArmThresholdRst = 10'd150;
  localparam logic [RcBitW-1:0]    RcLostBitRst    = 4'd2;

  // Periods in ms.
  localparam logic [TimeW-1:0] BlinkFailsafeMs = 32'd100;
  localparam logic [TimeW-1:0] BlinkErrorMs    = 32'd500;
  localparam logic [TimeW-1:0] ReportMs        = 32'd1000;

  typedef struct packed {
    state_e mode;
    logic   err;
  } eval_t;

  // Error / no-error evaluation in the given state.
  function automatic eval_t eval_fn(state_e m, logic err, logic has);
    eval_t r;
    r.mode = m;
    r.err  = err;
    case (m)
      StPreflight: begin
        if (has) begin
          r.err  = 1'b1;
          r.mode = StError;
        end
      end
      StError: begin
        if (!has) begin
          r.err  = 1'b0;
          r.mode = StPreflight;
        end
      end
      StCalibrating: begin
        if (has) begin
          r.err  = 1'b1;
          r.mode = StError;
        end else begin
          r.err = 1'b0;
        end
      end
      StArmed: begin
        r.err = has;
      end
      StFailsafe: begin
        if (has) begin
          r.err = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/arming_supervisor_fsm.sv
// Arming supervisor state machine with error mask, arm checks and status LED.
`default_nettype none

// Arming supervisor. Each input word carries one function code (tick, one of
// the seven events, set errors or clear errors) together with the error
// mask, throttle, override switch and current time; each accepted word gives
// exactly one result word with the state after the word, the armed, error and
// failsafe flags, the error mask, the status-report request, the calibration
// start pulse, the arm reject code and the LED level. Throughput is one word
// per clock: the whole step, including the nested error evaluation that a
// change of the error mask triggers, is settled by the combinational next
// state logic in the cycle of acceptance and lands in the state and result
// registers at that edge, so the result is valid in the cycle after acceptance.
// The result register lets a new word in while the held result is taken in
// the same cycle; only a result that is not taken stalls the input. Time
// comparisons are plain unsigned and do not handle wrap of now_ms. Write the
// configuration port only while the block is idle; registers take effect on
// the next word.
module arming_supervisor_fsm
  import asf_pkg::*;
#(
  parameter int unsigned ERROR_WIDTH = ErrorWidthDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,

  // configuration write port
  input  wire logic                 cfg_we_i,
  input  wire logic [CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [CfgDataW-1:0]  cfg_data_i,

  // input words
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [FuncW-1:0]     func_i,
  input  wire logic [MaskW-1:0]     error_mask_i,
  input  wire logic [ThrottleW-1:0] throttle_i,
  input  wire logic                 override_switch_i,
  input  wire logic [TimeW-1:0]     now_ms_i,

  // result words
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [2:0]                machine_state_o,
  output logic                      armed_flag_o,
  output logic                      error_flag_o,
  output logic                      failsafe_flag_o,
  output logic [MaskW-1:0]          error_bits_o,
  output logic                      status_update_o,
  output logic                      start_calibration_o,
  output logic [RejectW-1:0]        arm_reject_o,
  output logic                      led_on_o
);

  // Working width wide enough for both the port mask and the stored mask.
  localparam int unsigned ExtW = (ERROR_WIDTH > MaskW) ? ERROR_WIDTH : MaskW;

  // Configuration registers.
  logic [ThrottleW-1:0]   arm_threshold_q;
  logic                   take_min_q;
  logic                   cal_on_arm_q;
  logic [RcBitW-1:0]      rc_lost_bit_q;

  // Supervisor state.
  state_e                 mode_q, mode_d;
  logic                   armed_q, armed_d;
  logic                   error_q, error_d;
  logic                   failsafe_q, failsafe_d;
  logic [ERROR_WIDTH-1:0] store_q, store_d;
  logic [TimeW-1:0]       report_time_q, report_time_d;
  logic [TimeW-1:0]       blink_time_q, blink_time_d;
  logic                   led_q, led_d;

  // Result-only fields.
  logic                   out_valid_q;
  logic                   status_q, status_d;
  logic                   cal_q, cal_d;
  logic [RejectW-1:0]     reject_q, reject_d;

  logic                   in_fire;
  logic [ExtW-1:0]        mask_ext;
  logic [ExtW-1:0]        lost_ext;
  logic [ExtW-1:0]        store_ext;
  logic [ERROR_WIDTH-1:0] mask_in;
  logic [ERROR_WIDTH-1:0] lost;
  logic [ERROR_WIDTH-1:0] store_raise;
  logic [ERROR_WIDTH-1:0] store_drop;
  logic                   drop_hit;
  logic                   is_event;
  eval_t                  ev;

  // Take a new word whenever the result register is empty or being emptied.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // Fit the port mask and the rc lost bit to the stored mask width; a bit
  // position beyond the stored width drops out.
  assign mask_ext    = ExtW'(error_mask_i);
  assign mask_in     = mask_ext[ERROR_WIDTH-1:0];
  assign lost_ext    = ExtW'(1) << rc_lost_bit_q;
  assign lost        = lost_ext[ERROR_WIDTH-1:0];
  assign store_raise = store_q | lost;
  assign store_drop  = store_q & ~lost;
  assign drop_hit    = |(store_q & lost);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arm_threshold_q <= ArmThresholdRst;
      take_min_q      <= 1'b1;
      cal_on_arm_q    <= 1'b0;
      rc_lost_bit_q   <= RcLostBitRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgArmThreshold:    arm_threshold_q <= cfg_data_i;
        CfgTakeMinThrottle: take_min_q      <= cfg_data_i[0];
        CfgCalibrateOnArm:  cal_on_arm_q    <= cfg_data_i[0];
        CfgRcLostBit:       rc_lost_bit_q   <= cfg_data_i[RcBitW-1:0];
        default: ;
      endcase
    end
  end

  // State register; the state always equals what the latest result shows.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= StInit;
      armed_q       <= 1'b0;
      error_q       <= 1'b0;
      failsafe_q    <= 1'b0;
      store_q       <= '0;
      report_time_q <= '0;
      blink_time_q  <= '0;
      led_q         <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (in_fire) begin
        mode_q        <= mode_d;
        armed_q       <= armed_d;
        error_q       <= error_d;
        failsafe_q    <= failsafe_d;
        store_q       <= store_d;
        report_time_q <= report_time_d;
        blink_time_q  <= blink_time_d;
        led_q         <= led_d;
      end
      if (in_ready_o) begin
        out_valid_q <= in_fire;
      end
    end
  end

  // Result-only fields; no reset needed, guarded by out_valid_q.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      status_q <= status_d;
      cal_q    <= cal_d;
      reject_q <= reject_d;
    end
  end

  // Next state and result for one word.
  always_comb begin
    mode_d        = mode_q;
    armed_d       = armed_q;
    error_d       = error_q;
    failsafe_d    = failsafe_q;
    store_d       = store_q;
    report_time_d = report_time_q;
    blink_time_d  = blink_time_q;
    led_d         = led_q;
    status_d      = 1'b0;
    cal_d         = 1'b0;
    reject_d      = RejNone;
    is_event      = 1'b0;
    ev            = eval_fn(mode_q, error_q, |store_q);

    case (func_i)
      FuncTick: begin
        // Re-evaluate errors, then drive the LED from the updated error flag.
        mode_d  = ev.mode;
        error_d = ev.err;
        if (failsafe_q) begin
          if (blink_time_q < now_ms_i) begin
            led_d        = !led_q;
            blink_time_d = now_ms_i + BlinkFailsafeMs;
          end
        end else if (ev.err) begin
          if (blink_time_q < now_ms_i) begin
            led_d        = !led_q;
            blink_time_d = now_ms_i + BlinkErrorMs;
          end
        end else begin
          led_d = armed_q;
        end
      end

      FuncSetErr: begin
        store_d = store_q | mask_in;
        ev      = eval_fn(mode_q, error_q, |(store_q | mask_in));
        mode_d  = ev.mode;
        error_d = ev.err;
      end

      FuncClrErr: begin
        // Act only when some requested bit is currently set.
        if (|(store_q & mask_in)) begin
          store_d  = store_q & ~mask_in;
          ev       = eval_fn(mode_q, error_q, |(store_q & ~mask_in));
          mode_d   = ev.mode;
          error_d  = ev.err;
          status_d = 1'b1;
        end
      end

      FuncInitDone, FuncRcFound, FuncRcLost, FuncArm,
      FuncDisarm, FuncCalDone, FuncCalFail: begin
        is_event = 1'b1;
        case (mode_q)
          StInit: begin
            if (func_i == FuncInitDone) begin
              mode_d = StPreflight;
            end
          end

          StPreflight, StError: begin
            if (func_i == FuncRcFound) begin
              if (drop_hit) begin
                store_d  = store_drop;
                ev       = eval_fn(mode_q, error_q, |store_drop);
                mode_d   = ev.mode;
                error_d  = ev.err;
                status_d = 1'b1;
              end
              failsafe_d = 1'b0;
            end else if (func_i == FuncRcLost) begin
              store_d = store_raise;
              ev      = eval_fn(mode_q, error_q, |store_raise);
              mode_d  = ev.mode;
              error_d = ev.err;
            end else if (func_i == FuncArm) begin
              if (mode_q == StError) begin
                // Rate-limited error report while arming is refused.
                if (report_time_q < now_ms_i) begin
                  reject_d      = RejReport;
                  report_time_d = now_ms_i + ReportMs;
                end
              end else if (throttle_i < arm_threshold_q) begin
                if (take_min_q || override_switch_i) begin
                  if (cal_on_arm_q) begin
                    mode_d = StCalibrating;
                    cal_d  = 1'b1;
                  end else begin
                    armed_d = 1'b1;
                    mode_d  = StArmed;
                  end
                end else begin
                  reject_d = RejOverride;
                end
              end else begin
                reject_d = RejThrottle;
              end
            end
          end

          StCalibrating: begin
            if (func_i == FuncCalDone) begin
              armed_d = 1'b1;
              mode_d  = StArmed;
            end else if (func_i == FuncCalFail) begin
              mode_d = StPreflight;
            end else if (func_i == FuncRcLost) begin
              store_d = store_raise;
              ev      = eval_fn(mode_q, error_q, |store_raise);
              mode_d  = ev.mode;
              error_d = ev.err;
            end
          end

          StArmed: begin
            if (func_i == FuncRcLost) begin
              // Enter failsafe first, then evaluate the raised error there.
              failsafe_d = 1'b1;
              store_d    = store_raise;
              ev         = eval_fn(StFailsafe, error_q, |store_raise);
              mode_d     = ev.mode;
              error_d    = ev.err;
              status_d   = 1'b1;
            end else if (func_i == FuncDisarm) begin
              armed_d = 1'b0;
              mode_d  = error_q ? StError : StPreflight;
            end
          end

          StFailsafe: begin
            if (func_i == FuncDisarm) begin
              armed_d = 1'b0;
              mode_d  = StError;
            end else if (func_i == FuncRcFound) begin
              // Back to armed, then drop the rc lost error evaluated as armed.
              failsafe_d = 1'b0;
              mode_d     = StArmed;
              if (drop_hit) begin
                store_d  = store_drop;
                ev       = eval_fn(StArmed, error_q, |store_drop);
                mode_d   = ev.mode;
                error_d  = ev.err;
                status_d = 1'b1;
              end
            end
          end

          default: ;
        endcase
      end

      default: ;
    endcase

    // Request a status report on any state change, and on a mask change
    // caused by an event.
    if (mode_d != mode_q) begin
      status_d = 1'b1;
    end
    if (is_event && (store_d != store_q)) begin
      status_d = 1'b1;
    end
  end

  assign store_ext           = ExtW'(store_q);
  assign out_valid_o         = out_valid_q;
  assign machine_state_o     = mode_q;
  assign armed_flag_o        = armed_q;
  assign error_flag_o        = error_q;
  assign failsafe_flag_o     = failsafe_q;
  assign error_bits_o        = store_ext[MaskW-1:0];
  assign status_update_o     = status_q;
  assign start_calibration_o = cal_q;
  assign arm_reject_o        = reject_q;
  assign led_on_o            = led_q;

  // Armed exactly in the armed and failsafe states.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    armed_q == ((mode_q == StArmed) || (mode_q == StFailsafe)))
    else $error("armed flag out of step with state");

  // A calibration pulse only comes with the calibrating state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && cal_q) |-> (mode_q == StCalibrating))
    else $error("calibration pulse outside calibrating state");

  // An error report reject only in the error state, others only in preflight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (reject_q == RejReport)) |-> (mode_q == StError))
    else $error("error report outside error state");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && ((reject_q == RejThrottle) || (reject_q == RejOverride)))
      |-> (mode_q == StPreflight))
    else $error("arm check reject outside preflight");

  // State holds while a result is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(mode_q) &&
      $stable(store_q) && $stable(led_q)))
    else $error("state moved while result stalled");

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Testbench for the arming supervisor: directed and random words checked against a local predictor.
`timescale 1ns / 1ps

module tb;
  import asf_pkg::*;

  // Function codes the block ignores; the result just shows the current state.
  localparam logic [FuncW-1:0] FuncUnusedLo = 4'd10;
  localparam logic [FuncW-1:0] FuncUnusedHi = 4'd15;

  // One input word as the driver applies it.
  typedef struct packed {
    logic [FuncW-1:0]     func;
    logic [MaskW-1:0]     mask;
    logic [ThrottleW-1:0] throttle;
    logic                 override_sw;
    logic [TimeW-1:0]     now_ms;
  } sup_cmd_t;

  // One result word as the supervisor should report it.
  typedef struct packed {
    logic [2:0]         st;
    logic               armed;
    logic               err;
    logic               failsafe;
    logic [MaskW-1:0]   bits;
    logic               status;
    logic               cal;
    logic [RejectW-1:0] reject;
    logic               led;
  } sup_status_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CfgIdxW-1:0]   cfg_index_i;
  logic [CfgDataW-1:0]  cfg_data_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [FuncW-1:0]     func_i;
  logic [MaskW-1:0]     error_mask_i;
  logic [ThrottleW-1:0] throttle_i;
  logic                 override_switch_i;
  logic [TimeW-1:0]     now_ms_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [2:0]           machine_state_o;
  logic                 armed_flag_o;
  logic                 error_flag_o;
  logic                 failsafe_flag_o;
  logic [MaskW-1:0]     error_bits_o;
  logic                 status_update_o;
  logic                 start_calibration_o;
  logic [RejectW-1:0]   arm_reject_o;
  logic                 led_on_o;

  arming_supervisor_fsm dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .func_i              (func_i),
    .error_mask_i        (error_mask_i),
    .throttle_i          (throttle_i),
    .override_switch_i   (override_switch_i),
    .now_ms_i            (now_ms_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .machine_state_o     (machine_state_o),
    .armed_flag_o        (armed_flag_o),
    .error_flag_o        (error_flag_o),
    .failsafe_flag_o     (failsafe_flag_o),
    .error_bits_o        (error_bits_o),
    .status_update_o     (status_update_o),
    .start_calibration_o (start_calibration_o),
    .arm_reject_o        (arm_reject_o),
    .led_on_o            (led_on_o)
  );

  // Words waiting for the driver, and results the block still owes us.
  sup_cmd_t    cmd_backlog[$];
  sup_status_t due_status[$];

  // Predictor copy of the supervisor state.
  state_e           sv_mode;
  logic             sv_armed, sv_err, sv_fs, sv_led;
  logic [MaskW-1:0] sv_bits;
  logic [TimeW-1:0] sv_report_at, sv_blink_at;

  // Predictor copy of the configuration registers.
  logic [ThrottleW-1:0] cfg_arm_thr;
  logic                 cfg_take_min;
  logic                 cfg_cal_first;
  logic [RcBitW-1:0]    cfg_lost_pos;

  // Per-word outputs that the predictor builds up while it steps.
  logic               rpt_status, rpt_cal;
  logic [RejectW-1:0] rpt_reject;

  // Stimulus bookkeeping.
  logic [TimeW-1:0] wall_ms;
  int unsigned      cmds_made, cmds_taken, results_checked, mismatches, settings_run;
  int unsigned      cal_starts;
  logic [5:0]       states_seen;
  logic [3:0]       rejects_seen;

  // Handshake pacing.
  logic             took_word;
  int unsigned      gap_left, burst_left, ready_age;
  logic [15:0]      ready_mask;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Re-evaluate the state against "errors present" / "no errors"; a state
  // change asks for a status report.
  function automatic void settle_errors(input logic has);
    state_e was;
    was = sv_mode;
    case (sv_mode)
      StPreflight: begin
        if (has) begin
          sv_err  = 1'b1;
          sv_mode = StError;
        end
      end
      StError: begin
        if (!has) begin
          sv_err  = 1'b0;
          sv_mode = StPreflight;
        end
      end
      StCalibrating: begin
        if (has) begin
          sv_mode = StError;
          sv_err  = 1'b1;
        end else begin
          sv_err = 1'b0;
        end
      end
      StArmed: sv_err = has;
      StFailsafe: begin
        if (has) sv_err = 1'b1;
      end
      default: ;
    endcase
    if (sv_mode != was) rpt_status = 1'b1;
  endfunction

  function automatic void raise_errors(input logic [MaskW-1:0] m);
    sv_bits = sv_bits | m;
    settle_errors(sv_bits != '0);
  endfunction

  // Clearing acts only when one of the requested bits is actually set.
  function automatic void drop_errors(input logic [MaskW-1:0] m);
    if ((sv_bits & m) != '0) begin
      sv_bits = sv_bits & ~m;
      settle_errors(sv_bits != '0);
      rpt_status = 1'b1;
    end
  endfunction

  function automatic void handle_event(input logic [FuncW-1:0] f,
                                       input logic [ThrottleW-1:0] thr,
                                       input logic ovr, input logic [TimeW-1:0] now);
    state_e           was;
    logic [MaskW-1:0] was_bits;
    logic [MaskW-1:0] lost;
    was      = sv_mode;
    was_bits = sv_bits;
    lost     = MaskW'(1) << cfg_lost_pos;
    case (sv_mode)
      StInit: begin
        if (f == FuncInitDone) sv_mode = StPreflight;
      end
      StPreflight: begin
        if (f == FuncRcFound) begin
          drop_errors(lost);
          sv_fs = 1'b0;
        end else if (f == FuncRcLost) begin
          raise_errors(lost);
        end else if (f == FuncArm) begin
          if (thr >= cfg_arm_thr) begin
            rpt_reject = RejThrottle;
          end else if (!cfg_take_min && !ovr) begin
            rpt_reject = RejOverride;
          end else if (cfg_cal_first) begin
            sv_mode = StCalibrating;
            rpt_cal = 1'b1;
          end else begin
            sv_armed   = 1'b1;
            rpt_status = 1'b1;
            sv_mode    = StArmed;
          end
        end
      end
      StError: begin
        if (f == FuncRcLost) begin
          raise_errors(lost);
        end else if (f == FuncRcFound) begin
          drop_errors(lost);
          sv_fs = 1'b0;
        end else if (f == FuncArm && sv_report_at < now) begin
          // rate-limited error report, plain unsigned compare
          rpt_reject   = RejReport;
          sv_report_at = now + ReportMs;
        end
      end
      StCalibrating: begin
        if (f == FuncCalDone) begin
          sv_armed = 1'b1;
          sv_mode  = StArmed;
        end else if (f == FuncCalFail) begin
          sv_mode = StPreflight;
        end else if (f == FuncRcLost) begin
          raise_errors(lost);
        end
      end
      StArmed: begin
        if (f == FuncRcLost) begin
          sv_fs   = 1'b1;
          sv_mode = StFailsafe;
          raise_errors(lost);
          rpt_status = 1'b1;
        end else if (f == FuncDisarm) begin
          sv_armed = 1'b0;
          sv_mode  = sv_err ? StError : StPreflight;
        end
      end
      StFailsafe: begin
        if (f == FuncDisarm) begin
          sv_armed = 1'b0;
          sv_mode  = StError;
        end else if (f == FuncRcFound) begin
          sv_fs   = 1'b0;
          sv_mode = StArmed;
          drop_errors(lost);
        end
      end
      default: ;
    endcase
    if (sv_mode != was || sv_bits != was_bits) rpt_status = 1'b1;
  endfunction

  // LED: fast blink in failsafe, slow blink with errors, else follows armed.
  function automatic void drive_led(input logic [TimeW-1:0] now);
    if (sv_fs) begin
      if (sv_blink_at < now) begin
        sv_led      = !sv_led;
        sv_blink_at = now + BlinkFailsafeMs;
      end
    end else if (sv_err) begin
      if (sv_blink_at < now) begin
        sv_led      = !sv_led;
        sv_blink_at = now + BlinkErrorMs;
      end
    end else begin
      sv_led = sv_armed;
    end
  endfunction

  // Step the predictor by one accepted word and return the result it owes.
  function automatic sup_status_t supervise(input sup_cmd_t c);
    sup_status_t r;
    rpt_status = 1'b0;
    rpt_cal    = 1'b0;
    rpt_reject = RejNone;
    if (c.func == FuncTick) begin
      settle_errors(sv_bits != '0);
      drive_led(c.now_ms);
    end else if (c.func >= FuncInitDone && c.func <= FuncCalFail) begin
      handle_event(c.func, c.throttle, c.override_sw, c.now_ms);
    end else if (c.func == FuncSetErr) begin
      raise_errors(c.mask);
    end else if (c.func == FuncClrErr) begin
      drop_errors(c.mask);
    end
    r.st       = sv_mode;
    r.armed    = sv_armed;
    r.err      = sv_err;
    r.failsafe = sv_fs;
    r.bits     = sv_bits;
    r.status   = rpt_status;
    r.cal      = rpt_cal;
    r.reject   = rpt_reject;
    r.led      = sv_led;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, driver, receiver and monitor
  // ---------------------------------------------------------------------------

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Driver: change inputs at the falling edge only. Hold a word until it is
  // taken, then pull the next one from the backlog in bursts with gaps.
  always @(negedge clk_i) begin : driver
    sup_cmd_t c;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!(in_valid_i && !took_word)) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (cmd_backlog.size() != 0) begin
        c = cmd_backlog.pop_front();
        func_i            <= c.func;
        error_mask_i      <= c.mask;
        throttle_i        <= c.throttle;
        override_switch_i <= c.override_sw;
        now_ms_i          <= c.now_ms;
        in_valid_i        <= 1'b1;
        burst_left--;
        if (burst_left == 0) begin
          // new burst; a quarter of them follow on with no gap at all
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: rotate a stall pattern; swap it whenever ready_age runs out, often for
  // a pattern that never stalls. Bit 0 is forced so the pattern always drains.
  always @(negedge clk_i) begin
    if (ready_age == 0) begin
      ready_age  = 48;
      ready_mask = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
    end
    ready_age--;
    out_ready_i <= ready_mask[0];
    ready_mask  = {ready_mask[0], ready_mask[15:1]};
  end

  // Monitor: sample at the rising edge. Check the outgoing word first so a
  // word accepted at this same edge can never be matched against itself.
  always @(posedge clk_i) begin : monitor
    sup_status_t want;
    sup_cmd_t    c;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (due_status.size() == 0) begin
          $error("result word with no expectation pending (state %0d)", machine_state_o);
          mismatches++;
        end else begin
          want = due_status.pop_front();
          check_field("machine_state", 32'(want.st), 32'(machine_state_o));
          check_field("armed_flag", 32'(want.armed), 32'(armed_flag_o));
          check_field("error_flag", 32'(want.err), 32'(error_flag_o));
          check_field("failsafe_flag", 32'(want.failsafe), 32'(failsafe_flag_o));
          check_field("error_bits", 32'(want.bits), 32'(error_bits_o));
          check_field("status_update", 32'(want.status), 32'(status_update_o));
          check_field("start_calibration", 32'(want.cal), 32'(start_calibration_o));
          check_field("arm_reject", 32'(want.reject), 32'(arm_reject_o));
          check_field("led_on", 32'(want.led), 32'(led_on_o));
          results_checked++;
          if (want.st <= 3'd5) states_seen[want.st] = 1'b1;
          rejects_seen[want.reject] = 1'b1;
          if (want.cal) cal_starts++;
        end
      end
      if (in_valid_i && in_ready_o) begin
        c.func        = func_i;
        c.mask        = error_mask_i;
        c.throttle    = throttle_i;
        c.override_sw = override_switch_i;
        c.now_ms      = now_ms_i;
        due_status.push_back(supervise(c));
        cmds_taken++;
      end
      took_word <= in_valid_i && in_ready_o;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic queue_cmd(input logic [FuncW-1:0] f, input logic [MaskW-1:0] m,
                           input logic [ThrottleW-1:0] thr, input logic ovr,
                           input logic [TimeW-1:0] ms);
    sup_cmd_t c;
    c.func        = f;
    c.mask        = m;
    c.throttle    = thr;
    c.override_sw = ovr;
    c.now_ms      = ms;
    cmd_backlog.push_back(c);
    cmds_made++;
  endtask

  // Advance the time base. Mostly small forward steps (blink and report
  // periods get crossed often); now and then a jump anywhere or near wrap.
  function automatic logic [TimeW-1:0] step_clock();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 3)
      wall_ms = $urandom;
    else if (pick < 4)
      wall_ms = 32'hFFFF_FF00 + $urandom_range(0, 255);
    else
      wall_ms = wall_ms + $urandom_range(0, 250);
    return wall_ms;
  endfunction

  // Error mask to set: mostly the rc lost bit or one random bit.
  function automatic logic [MaskW-1:0] pick_errors();
    int unsigned pick;
    pick = $urandom_range(0, 3);
    if (pick < 2) return MaskW'(1) << cfg_lost_pos;
    if (pick == 2) return MaskW'(1) << $urandom_range(0, MaskW - 1);
    return MaskW'($urandom);
  endfunction

  function automatic logic [ThrottleW-1:0] pick_throttle(input logic low);
    if (low && cfg_arm_thr != 0) return ThrottleW'($urandom_range(0, cfg_arm_thr - 1));
    if (!low && cfg_arm_thr <= 10'd1000) return ThrottleW'($urandom_range(cfg_arm_thr, 1000));
    return ThrottleW'($urandom_range(0, 1000));
  endfunction

  task automatic queue_ticks(input int unsigned n);
    repeat (n) queue_cmd(FuncTick, MaskW'($urandom), pick_throttle(1'($urandom)),
                         1'($urandom), step_clock());
  endtask

  // Random words of any code, including the unused ones.
  task automatic queue_noise(input int unsigned n);
    repeat (n) queue_cmd(FuncW'($urandom_range(0, 15)), pick_errors() | MaskW'($urandom),
                         ThrottleW'($urandom_range(0, 1000)), 1'($urandom), step_clock());
  endtask

  // One well-formed flight: clear errors, find rc, arm (maybe via
  // calibration), fly a little, then lose rc, pick up errors or disarm.
  task automatic queue_flight();
    int unsigned pick;
    if ($urandom_range(0, 9) < 3) begin
      // sit in the error state and hammer arm to hit the report limiter
      queue_cmd(FuncRcLost, '0, '0, 1'b0, step_clock());
      queue_ticks(1);
      repeat ($urandom_range(1, 3))
        queue_cmd(FuncArm, MaskW'($urandom), pick_throttle(1'b1), 1'($urandom),
                  step_clock());
    end
    queue_cmd(FuncClrErr, ($urandom_range(0, 3) == 0) ? MaskW'($urandom) : '1,
              '0, 1'b0, step_clock());
    queue_cmd(FuncRcFound, MaskW'($urandom), '0, 1'b0, step_clock());
    queue_ticks($urandom_range(0, 2));
    queue_cmd(FuncArm, MaskW'($urandom), pick_throttle($urandom_range(0, 4) != 0),
              1'($urandom), step_clock());
    if (cfg_cal_first) begin
      pick = $urandom_range(0, 9);
      if (pick < 6)
        queue_cmd(FuncCalDone, '0, '0, 1'b0, step_clock());
      else if (pick < 8)
        queue_cmd(FuncCalFail, '0, '0, 1'b0, step_clock());
      else
        queue_cmd(FuncRcLost, '0, '0, 1'b0, step_clock());
    end
    queue_ticks($urandom_range(1, 5));
    case ($urandom_range(0, 3))
      0: begin
        queue_cmd(FuncRcLost, '0, '0, 1'b0, step_clock());
        queue_ticks($urandom_range(2, 8));
        queue_cmd($urandom_range(0, 1) ? FuncRcFound : FuncDisarm, '0, '0, 1'b0,
                  step_clock());
      end
      1: begin
        queue_cmd(FuncSetErr, pick_errors(), '0, 1'b0, step_clock());
        queue_ticks(1);
        queue_cmd(FuncDisarm, '0, '0, 1'b0, step_clock());
      end
      2: queue_cmd(FuncDisarm, '0, '0, 1'b0, step_clock());
      default: begin
        queue_cmd(FuncSetErr, pick_errors(), '0, 1'b0, step_clock());
        repeat ($urandom_range(1, 3))
          queue_cmd(FuncArm, '0, pick_throttle(1'b1), 1'($urandom), step_clock());
        queue_cmd(FuncClrErr, MaskW'($urandom), '0, 1'b0, step_clock());
      end
    endcase
    queue_ticks($urandom_range(1, 3));
  endtask

  // Block until every queued word has gone in and every result came back,
  // then let the pipeline settle before touching the registers.
  task automatic wait_quiet();
    do @(posedge clk_i);
    while (!(cmd_backlog.size() == 0 && !in_valid_i && due_status.size() == 0));
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgArmThreshold:    cfg_arm_thr   = data[ThrottleW-1:0];
      CfgTakeMinThrottle: cfg_take_min  = data[0];
      CfgCalibrateOnArm:  cfg_cal_first = data[0];
      CfgRcLostBit:       cfg_lost_pos  = data[RcBitW-1:0];
      default: ;
    endcase
  endtask

  // Program all registers, then run a mix of flights and noise until about
  // n_cmds words have been queued, and drain.
  task automatic run_setting(input logic [ThrottleW-1:0] thr, input logic take_min,
                             input logic cal_first, input logic [RcBitW-1:0] pos,
                             input int unsigned n_cmds);
    int unsigned goal;
    write_reg(CfgArmThreshold, CfgDataW'(thr));
    write_reg(CfgTakeMinThrottle, CfgDataW'(take_min));
    write_reg(CfgCalibrateOnArm, CfgDataW'(cal_first));
    write_reg(CfgRcLostBit, CfgDataW'(pos));
    settings_run++;
    goal = cmds_made + n_cmds;
    while (cmds_made < goal) begin
      if ($urandom_range(0, 4) != 0)
        queue_flight();
      else
        queue_noise($urandom_range(1, 5));
    end
    wait_quiet();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_index_i       = '0;
    cfg_data_i        = '0;
    in_valid_i        = 1'b0;
    func_i            = FuncTick;
    error_mask_i      = '0;
    throttle_i        = '0;
    override_switch_i = 1'b0;
    now_ms_i          = '0;
    out_ready_i       = 1'b0;
    took_word         = 1'b0;
    gap_left          = 0;
    burst_left        = 1;
    ready_age         = 0;
    ready_mask        = '1;

    // Predictor starts where the block does after reset.
    sv_mode       = StInit;
    sv_armed      = 1'b0;
    sv_err        = 1'b0;
    sv_fs         = 1'b0;
    sv_led        = 1'b0;
    sv_bits       = '0;
    sv_report_at  = '0;
    sv_blink_at   = '0;
    cfg_arm_thr   = ArmThresholdRst;
    cfg_take_min  = 1'b1;
    cfg_cal_first = 1'b0;
    cfg_lost_pos  = RcLostBitRst;

    cmds_made       = 0;
    cmds_taken      = 0;
    results_checked = 0;
    mismatches      = 0;
    settings_run    = 1;
    cal_starts      = 0;
    states_seen     = '0;
    rejects_seen    = '0;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed walk with the reset register values.
    queue_cmd(FuncTick, '0, '0, 1'b0, 32'd0);             // tick while still in init
    queue_cmd(FuncArm, '0, '0, 1'b1, 32'd1);              // arm ignored in init
    queue_cmd(FuncSetErr, 16'h8001, '0, 1'b0, 32'd2);     // errors stored, no state change
    queue_cmd(FuncUnusedHi, '1, 10'd1000, 1'b1, 32'd3);   // unused code: nothing moves
    queue_cmd(FuncInitDone, '0, '0, 1'b0, 32'd4);
    queue_cmd(FuncTick, '0, '0, 1'b0, 32'd10);            // stored errors push to error state
    queue_cmd(FuncArm, '0, '0, 1'b0, 32'd5);              // first error report
    queue_cmd(FuncArm, '0, '0, 1'b0, 32'd1005);           // deadline equal to now: no report
    queue_cmd(FuncArm, '0, '0, 1'b0, 32'd1006);           // one past: report again
    queue_cmd(FuncClrErr, 16'h0001, '0, 1'b0, 32'd1010);  // partial clear, error remains
    queue_cmd(FuncClrErr, 16'h0002, '0, 1'b0, 32'd1011);  // bit not set: no effect
    queue_cmd(FuncRcLost, '0, '0, 1'b0, 32'd1012);
    queue_cmd(FuncRcFound, '0, '0, 1'b0, 32'd1013);
    queue_cmd(FuncClrErr, '1, '0, 1'b0, 32'd1014);        // back to preflight
    queue_cmd(FuncArm, '0, 10'd1000, 1'b1, 32'd1015);     // throttle at top
    queue_cmd(FuncArm, '0, 10'd150, 1'b1, 32'd1016);      // throttle equal to threshold
    queue_cmd(FuncArm, '1, 10'd149, 1'b0, 32'd1017);      // arms without the switch
    queue_cmd(FuncTick, '0, '0, 1'b0, 32'd1018);          // LED follows armed
    queue_cmd(FuncRcLost, '0, '0, 1'b0, 32'd1019);        // armed -> failsafe
    queue_cmd(FuncTick, '0, '0, 1'b0, 32'd1020);          // fast blink
    queue_cmd(FuncTick, '0, '0, 1'b0, 32'd1121);
    queue_cmd(FuncRcFound, '0, '0, 1'b0, 32'd1122);       // failsafe -> armed
    queue_cmd(FuncSetErr, '1, '0, 1'b0, 32'd1123);        // error flag while armed
    queue_cmd(FuncDisarm, '0, '0, 1'b0, 32'd1124);        // lands in error state
    queue_cmd(FuncTick, '0, '0, 1'b0, 32'hFFFF_FFFF);     // time at its top
    queue_cmd(FuncClrErr, '1, '0, 1'b0, 32'hFFFF_FFFF);
    queue_cmd(FuncUnusedLo, 16'h5A5A, 10'd512, 1'b1, 32'd0);
    wait_quiet();

    // Random flights over several register settings, extremes included.
    wall_ms = 32'd2000;
    run_setting(10'd1000, 1'b0, 1'b0, 4'd0, 235);
    run_setting(10'd0, 1'b1, 1'b1, 4'd15, 235);
    run_setting(10'd150, 1'b1, 1'b0, 4'd2, 235);
    run_setting(ThrottleW'($urandom_range(1, 999)), 1'b0, 1'b1,
                RcBitW'($urandom_range(3, 14)), 235);
    run_setting(10'd1, 1'b1, 1'b0, 4'd7, 235);
    run_setting(10'd600, 1'b0, 1'b1, RcBitW'($urandom_range(0, 15)), 235);

    repeat (8) @(posedge clk_i);
    if (due_status.size() != 0) begin
      $error("%0d results never arrived", due_status.size());
      mismatches++;
    end
    $display("summary: %0d words over %0d register settings, %0d results checked",
             cmds_taken, settings_run, results_checked);
    $display("summary: states seen %b, reject codes seen %b, %0d calibration starts",
             states_seen, rejects_seen, cal_starts);
    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("tb: FAIL");
    $finish;
  end

endmodule
